/* rtl/rssr_pkg.sv */
// shared types and constants of the rss redirection table rebalancer
// used by the controller, the datapath, the divider and the top level
package rssr_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = 6;
	localparam int LOAD_W      = 64;
	localparam int QV_W        = 8;
	localparam int QC_W        = 5;
	localparam int DIVISOR_W   = 8;
	localparam int DIV_CNT_W   = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_QCOUNT = 1'b1;

	typedef enum logic [1:0] {
		OPC_BASE  = 2'd0,
		OPC_COUNT = 2'd1,
		OPC_FILL  = 2'd2,
		OPC_WRITE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		RS_REBAL = 3'd0,
		RS_OFF   = 3'd1,
		RS_FEW   = 3'd2,
		RS_DOM   = 3'd3,
		RS_BAL   = 3'd4
	} rstat_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_PREV_WR,
		OP_TAB_WR,
		OP_FILL,
		OP_CNT_RD,
		OP_CNT_WR,
		OP_LOAD_CLR,
		OP_ACC_RD,
		OP_ACC_LD,
		OP_ACC_WR,
		OP_SRCH_RD,
		OP_SRCH_CMP,
		OP_GAP,
		OP_MOV_RD,
		OP_MOV_CHK,
		OP_REP_RD,
		OP_REP_OUT,
		OP_DELTA_CLR
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PREV_WR,
		S_TAB_WR,
		S_FILL,
		S_CNT_RD,
		S_CNT_WR,
		S_LCLR,
		S_ACC_RD,
		S_ACC_LD,
		S_ACC_WR,
		S_DOM,
		S_DIV,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_GAP,
		S_MOV_RD,
		S_MOV_CHK,
		S_REP_RD,
		S_REP_OUT,
		S_DCLR
	} ctl_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   capture;
		logic   idx_clr;
		logic   idx_inc;
		logic   div_start;
		logic   status_we;
		rstat_t status_code;
	} dp_cmd_t;

	typedef struct packed {
		logic rebal_ok;
		logic i_last;
		logic j_last;
		logic idx_end;
		logic few;
		logic dom;
		logic bal;
		logic rem_zero;
		logic div_busy;
	} dp_st_t;

endpackage

/* rtl/rssr_ram.sv */
// generic single write port, single read port ram with registered read
// no package dependency
module rssr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/rssr_div.sv */
// restoring divider, one quotient bit per cycle
// depends on rssr_pkg for the operand widths
module rssr_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rssr_pkg::LOAD_W-1:0]     dividend,
	input  logic [rssr_pkg::DIVISOR_W-1:0]  divisor,
	output logic                            busy,
	output logic [rssr_pkg::LOAD_W-1:0]     quotient
);
	import rssr_pkg::*;

	logic [LOAD_W-1:0]    quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIVISOR_W:0]   shifted;
	logic                 fits;
	logic [DIVISOR_W:0]   diff;

	assign shifted = {rem_q, quo_q[LOAD_W-1]};
	assign fits    = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == {DIV_CNT_W{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[LOAD_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* rtl/rssr_datapath.sv */
// datapath: config registers, count, delta, table and load memories,
// round arithmetic and the report register; uses rssr_pkg, rssr_ram, rssr_div
module rssr_datapath #(
	parameter int MAX_QUEUES  = 16,
	parameter int COUNT_WIDTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rssr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rssr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [rssr_pkg::IDX_W-1:0]        entry_index,
	input  logic [63:0]                       packet_count,
	input  logic [rssr_pkg::QV_W-1:0]         queue_value,
	input  rssr_pkg::dp_cmd_t                 cmd,
	output rssr_pkg::dp_st_t                  st,
	output logic                              result_valid,
	output logic [rssr_pkg::IDX_W-1:0]        entry_index_out,
	output logic [rssr_pkg::QV_W-1:0]         queue_out,
	output logic                              reassigned,
	output logic [2:0]                        round_status,
	output logic                              last_out
);
	import rssr_pkg::*;

	localparam int QA = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam logic [QC_W-1:0] MAXQ = QC_W'(MAX_QUEUES);

	logic            en_q;
	logic [QC_W-1:0] qc_q;
	logic [QC_W-1:0] qeff;
	logic [QC_W-1:0] q_last;
	logic [IDX_W:0]  n_ext;
	logic [IDX_W-1:0] n_last;

	logic [IDX_W-1:0]       idx_in_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [QV_W-1:0]        qv_q;
	logic [IDX_W-1:0]       idx_q;
	logic [QC_W-1:0]        fill_q;

	logic [TABLE_DEPTH-1:0] pv_q, tv_q;
	logic                   pv_rd_q, tv_rd_q;

	logic                   p_we;
	logic [COUNT_WIDTH-1:0] p_rdata, prev_val;
	logic                   d_we;
	logic [IDX_W-1:0]       d_waddr;
	logic [COUNT_WIDTH-1:0] d_wdata, d_rdata;
	logic                   t_we;
	logic [IDX_W-1:0]       t_waddr;
	logic [QV_W:0]          t_wdata, t_rdata, tab_val;
	logic                   l_we;
	logic [QA-1:0]          l_waddr, l_raddr;
	logic [LOAD_W-1:0]      l_wdata, l_rdata;

	logic [IDX_W:0]         act_q;
	logic [LOAD_W-1:0]      total_q;
	logic [COUNT_WIDTH-1:0] maxd_q;
	logic [LOAD_W-1:0]      maxl_q, minl_q, rem_q, thr;
	logic [QA-1:0]          maxq_q, minq_q;
	rstat_t                 status_q;

	logic [LOAD_W-1:0] d_ext, gap, half_gap, rem_nx, sat_load, sat_total;
	logic [LOAD_W:0]   sum_load, sum_total;
	logic              t_in, hit;
	logic [DIVISOR_W-1:0] divisor;
	logic              div_busy;

	logic                 valid_q, ra_q, lo_q;
	logic [IDX_W-1:0]     eio_q;
	logic [QV_W-1:0]      qo_q;
	logic [2:0]           rs_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			qc_q <= QC_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE: en_q <= cfg_data[0];
				CFG_QCOUNT: qc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		qeff = qc_q;
		if (qeff == '0) begin
			qeff = QC_W'(1);
		end
		if (qeff > MAXQ) begin
			qeff = MAXQ;
		end
	end

	assign q_last = qeff - 1'b1;
	assign n_ext  = {qeff, 2'b00} - 1'b1;
	assign n_last = n_ext[IDX_W-1:0];

	assign prev_val = pv_rd_q ? p_rdata : '0;
	assign tab_val  = tv_rd_q ? t_rdata : '0;
	assign d_ext    = LOAD_W'(d_rdata);

	assign t_in      = tab_val[QV_W-1:0] < QV_W'(qeff);
	assign sum_load  = {1'b0, l_rdata} + {1'b0, d_ext};
	assign sum_total = {1'b0, total_q} + {1'b0, d_ext};
	assign sat_load  = sum_load[LOAD_W] ? '1 : sum_load[LOAD_W-1:0];
	assign sat_total = sum_total[LOAD_W] ? '1 : sum_total[LOAD_W-1:0];

	assign gap      = maxl_q - minl_q;
	assign half_gap = gap >> 1;
	assign hit      = (tab_val[QV_W-1:0] == QV_W'(maxq_q)) && (d_rdata != '0);
	always_comb begin
		rem_nx = rem_q;
		if (hit) begin
			rem_nx = (d_ext >= rem_q) ? '0 : rem_q - d_ext;
		end
	end

	// 10 * q as shifts
	assign divisor = DIVISOR_W'({qeff, 3'b000}) + DIVISOR_W'({qeff, 1'b0});

	// memory ports
	assign p_we = (cmd.op == OP_PREV_WR) || (cmd.op == OP_CNT_WR);

	assign d_we    = (cmd.op == OP_CNT_WR) || (cmd.op == OP_DELTA_CLR);
	assign d_waddr = (cmd.op == OP_CNT_WR) ? idx_in_q : idx_q;
	assign d_wdata = (cmd.op == OP_CNT_WR) ? cnt_q - prev_val : '0;

	always_comb begin
		t_we    = 1'b0;
		t_waddr = idx_q;
		t_wdata = {1'b0, tab_val[QV_W-1:0]};
		case (cmd.op)
			OP_TAB_WR: begin
				t_we    = 1'b1;
				t_waddr = idx_in_q;
				t_wdata = {1'b0, qv_q};
			end
			OP_FILL: begin
				t_we    = 1'b1;
				t_wdata = {1'b0, QV_W'(fill_q)};
			end
			OP_MOV_CHK: begin
				t_we    = hit;
				t_wdata = {1'b1, QV_W'(minq_q)};
			end
			OP_REP_OUT: begin
				// clears the moved mark of this round
				t_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		l_we    = 1'b0;
		l_waddr = idx_q[QA-1:0];
		l_wdata = '0;
		case (cmd.op)
			OP_LOAD_CLR: l_we = 1'b1;
			OP_ACC_WR: begin
				l_we    = t_in;
				l_waddr = tab_val[QA-1:0];
				l_wdata = sat_load;
			end
			default: ;
		endcase
	end

	assign l_raddr = (cmd.op == OP_ACC_LD) ? tab_val[QA-1:0] : idx_q[QA-1:0];

	rssr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TABLE_DEPTH)) u_prev (
		.clk(clk), .we(p_we), .waddr(idx_in_q), .wdata(cnt_q),
		.raddr(idx_in_q), .rdata(p_rdata)
	);

	rssr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TABLE_DEPTH)) u_delta (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(idx_q), .rdata(d_rdata)
	);

	rssr_ram #(.WIDTH(QV_W + 1), .DEPTH(TABLE_DEPTH)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(idx_q), .rdata(t_rdata)
	);

	rssr_ram #(.WIDTH(LOAD_W), .DEPTH(MAX_QUEUES)) u_load (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	rssr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(total_q), .divisor(divisor),
		.busy(div_busy), .quotient(thr)
	);

	// valid bits of the two stores that reset clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= '0;
			tv_q    <= '0;
			pv_rd_q <= 1'b0;
			tv_rd_q <= 1'b0;
		end else begin
			if (p_we) begin
				pv_q[idx_in_q] <= 1'b1;
			end
			if (t_we) begin
				tv_q[t_waddr] <= 1'b1;
			end
			pv_rd_q <= pv_q[idx_in_q];
			tv_rd_q <= tv_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			status_q <= RS_OFF;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.status_we) begin
				status_q <= cmd.status_code;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_in_q <= entry_index;
			cnt_q    <= packet_count[COUNT_WIDTH-1:0];
			qv_q     <= queue_value;
			fill_q   <= '0;
		end
		case (cmd.op)
			OP_FILL: fill_q <= (fill_q == q_last) ? '0 : fill_q + 1'b1;
			OP_LOAD_CLR: begin
				act_q   <= '0;
				total_q <= '0;
				maxd_q  <= '0;
			end
			OP_ACC_LD: begin
				if (d_rdata != '0) begin
					act_q <= act_q + 1'b1;
				end
				if (d_rdata > maxd_q) begin
					maxd_q <= d_rdata;
				end
			end
			OP_ACC_WR: begin
				if (t_in) begin
					total_q <= sat_total;
				end
			end
			OP_SRCH_CMP: begin
				if (idx_q == '0) begin
					maxl_q <= l_rdata;
					minl_q <= l_rdata;
					maxq_q <= '0;
					minq_q <= '0;
				end else begin
					if (l_rdata > maxl_q) begin
						maxl_q <= l_rdata;
						maxq_q <= idx_q[QA-1:0];
					end
					if (l_rdata < minl_q) begin
						minl_q <= l_rdata;
						minq_q <= idx_q[QA-1:0];
					end
				end
			end
			OP_GAP: rem_q <= (half_gap == '0) ? LOAD_W'(1) : half_gap;
			OP_MOV_CHK: rem_q <= rem_nx;
			default: ;
		endcase
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (cmd.op == OP_REP_OUT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_REP_OUT) begin
			eio_q <= idx_q;
			qo_q  <= tab_val[QV_W-1:0];
			ra_q  <= tab_val[QV_W];
			rs_q  <= status_q;
			lo_q  <= (idx_q == n_last);
		end
	end

	assign st.rebal_ok = en_q && (qeff > QC_W'(1));
	assign st.i_last   = (idx_q == n_last);
	assign st.j_last   = (idx_q == IDX_W'(q_last));
	assign st.idx_end  = (idx_q == IDX_W'(TABLE_DEPTH - 1));
	assign st.few      = act_q <= (IDX_W + 1)'(qeff);
	assign st.dom      = LOAD_W'(maxd_q) >= (total_q >> 1);
	assign st.bal      = (gap <= thr) || (maxq_q == minq_q);
	assign st.rem_zero = (rem_nx == '0);
	assign st.div_busy = div_busy;

	assign result_valid    = valid_q;
	assign entry_index_out = eio_q;
	assign queue_out       = qo_q;
	assign reassigned      = ra_q;
	assign round_status    = rs_q;
	assign last_out        = lo_q;

endmodule

/* rtl/rssr_ctrl.sv */
// controller state machine sequencing item handling and the round decision
// uses rssr_pkg for states, commands and status
module rssr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           opcode,
	input  logic                 last,
	input  rssr_pkg::dp_st_t     st,
	output rssr_pkg::dp_cmd_t    cmd,
	output logic                 busy
);
	import rssr_pkg::*;

	ctl_state_t state_q, state_nx;
	logic       last_q;
	opcode_t    opc;

	assign opc = opcode_t'(opcode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_IDLE && start) begin
				last_q <= last;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (opc)
						OPC_BASE:  state_nx = S_PREV_WR;
						OPC_WRITE: state_nx = S_TAB_WR;
						OPC_FILL:  state_nx = S_FILL;
						OPC_COUNT: begin
							if (st.rebal_ok) begin
								state_nx = S_CNT_RD;
							end else if (last) begin
								state_nx = S_REP_RD;
							end
						end
					endcase
				end
			end
			S_PREV_WR, S_TAB_WR: state_nx = S_IDLE;
			S_FILL:     if (st.i_last) state_nx = S_IDLE;
			S_CNT_RD:   state_nx = S_CNT_WR;
			S_CNT_WR:   state_nx = last_q ? S_LCLR : S_IDLE;
			S_LCLR:     if (st.j_last) state_nx = S_ACC_RD;
			S_ACC_RD:   state_nx = S_ACC_LD;
			S_ACC_LD:   state_nx = S_ACC_WR;
			S_ACC_WR:   state_nx = st.i_last ? S_DOM : S_ACC_RD;
			S_DOM:      state_nx = (st.few || st.dom) ? S_REP_RD : S_DIV;
			S_DIV:      if (!st.div_busy) state_nx = S_SRCH_RD;
			S_SRCH_RD:  state_nx = S_SRCH_CMP;
			S_SRCH_CMP: state_nx = st.j_last ? S_GAP : S_SRCH_RD;
			S_GAP:      state_nx = st.bal ? S_REP_RD : S_MOV_RD;
			S_MOV_RD:   state_nx = S_MOV_CHK;
			S_MOV_CHK:  state_nx = (st.i_last || st.rem_zero) ? S_REP_RD : S_MOV_RD;
			S_REP_RD:   state_nx = S_REP_OUT;
			S_REP_OUT:  state_nx = st.i_last ? S_DCLR : S_REP_RD;
			S_DCLR:     if (st.idx_end) state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.op          = OP_NONE;
		cmd.status_code = RS_REBAL;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					cmd.idx_clr = 1'b1;
					if (opc == OPC_COUNT && !st.rebal_ok) begin
						cmd.status_we   = 1'b1;
						cmd.status_code = RS_OFF;
					end
				end
			end
			S_PREV_WR: cmd.op = OP_PREV_WR;
			S_TAB_WR:  cmd.op = OP_TAB_WR;
			S_FILL: begin
				cmd.op      = OP_FILL;
				cmd.idx_inc = 1'b1;
			end
			S_CNT_RD: cmd.op = OP_CNT_RD;
			S_CNT_WR: begin
				cmd.op      = OP_CNT_WR;
				cmd.idx_clr = 1'b1;
			end
			S_LCLR: begin
				cmd.op      = OP_LOAD_CLR;
				cmd.idx_clr = st.j_last;
				cmd.idx_inc = !st.j_last;
			end
			S_ACC_RD: cmd.op = OP_ACC_RD;
			S_ACC_LD: cmd.op = OP_ACC_LD;
			S_ACC_WR: begin
				cmd.op      = OP_ACC_WR;
				cmd.idx_clr = st.i_last;
				cmd.idx_inc = !st.i_last;
			end
			S_DOM: begin
				if (st.few) begin
					cmd.status_we   = 1'b1;
					cmd.status_code = RS_FEW;
				end else if (st.dom) begin
					cmd.status_we   = 1'b1;
					cmd.status_code = RS_DOM;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			S_DIV:     cmd.op = OP_NONE;
			S_SRCH_RD: cmd.op = OP_SRCH_RD;
			S_SRCH_CMP: begin
				cmd.op      = OP_SRCH_CMP;
				cmd.idx_clr = st.j_last;
				cmd.idx_inc = !st.j_last;
			end
			S_GAP: begin
				cmd.op          = OP_GAP;
				cmd.status_we   = 1'b1;
				cmd.status_code = st.bal ? RS_BAL : RS_REBAL;
			end
			S_MOV_RD: cmd.op = OP_MOV_RD;
			S_MOV_CHK: begin
				cmd.op      = OP_MOV_CHK;
				cmd.idx_clr = st.i_last || st.rem_zero;
				cmd.idx_inc = !(st.i_last || st.rem_zero);
			end
			S_REP_RD: cmd.op = OP_REP_RD;
			S_REP_OUT: begin
				cmd.op      = OP_REP_OUT;
				cmd.idx_clr = st.i_last;
				cmd.idx_inc = !st.i_last;
			end
			S_DCLR: begin
				cmd.op      = OP_DELTA_CLR;
				cmd.idx_inc = 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* rtl/rss_indirection_rebalancer.sv */
// rss redirection table rebalancer: four table entries per receive queue,
// moves entries from the busiest to the idlest queue at most once per count round.
// An item is accepted at a clock edge with start high and busy low; busy
// stays high until the item is fully handled.
// A table fill writes the 4*q entries in turn. A periodic count without the
// last mark updates the baseline and delta memories, or does nothing while
// disabled or with one queue. One with the last mark closes the round: a
// clear of q queue loads, a walk of the 4*q entries through the table,
// delta and load memories, a radix-2 divider for the balance threshold, a
// search over the queues, a move walk that stops once enough load has
// moved, the report of every entry and a pass that zeroes the 64 delta
// entries; the steps before the report end once the status is settled.
// Each report item sits on the result ports for one cycle with result_valid
// high, last_out on the final entry; the receiver cannot stall. Reset clears
// the table and baseline counts through valid bits, so no clearing pass is
// needed; configuration writes are to be taken only while idle, which the
// block does not enforce. Uses rssr_pkg, rssr_ctrl and rssr_datapath.
module rss_indirection_rebalancer #(
	parameter int MAX_QUEUES  = 16,
	parameter int COUNT_WIDTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rssr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rssr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        opcode,
	input  logic [rssr_pkg::IDX_W-1:0]        entry_index,
	input  logic [63:0]                       packet_count,
	input  logic [rssr_pkg::QV_W-1:0]         queue_value,
	input  logic                              last,
	output logic                              result_valid,
	output logic [rssr_pkg::IDX_W-1:0]        entry_index_out,
	output logic [rssr_pkg::QV_W-1:0]         queue_out,
	output logic                              reassigned,
	output logic [2:0]                        round_status,
	output logic                              last_out
);
	import rssr_pkg::*;

	dp_cmd_t cmd;
	dp_st_t  st;

	rssr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.last(last), .st(st), .cmd(cmd), .busy(busy)
	);

	rssr_datapath #(.MAX_QUEUES(MAX_QUEUES), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.entry_index(entry_index), .packet_count(packet_count),
		.queue_value(queue_value), .cmd(cmd), .st(st),
		.result_valid(result_valid), .entry_index_out(entry_index_out),
		.queue_out(queue_out), .reassigned(reassigned),
		.round_status(round_status), .last_out(last_out)
	);

endmodule

/* tb/testbench.sv */
// testbench of the rss redirection table rebalancer: a scoreboard class predicts
// every report entry, plain tasks drive the command and configuration ports
// depends on rssr_pkg and rss_indirection_rebalancer
module testbench;
	import rssr_pkg::*;

	typedef struct packed {
		logic [5:0] idx;
		logic [7:0] queue;
		logic       moved;
		rstat_t     status;
		logic       lastf;
	} report_t;

	class rebalance_scoreboard;
		bit          enable_r;
		bit [4:0]    qcount_r;
		bit [63:0]   prev_cnt[64];
		bit [7:0]    table_q[64];
		bit [63:0]   delta[64];
		bit          moved[64];
		report_t     pending[$];
		int          errors;
		int          checked;
		int          rounds;
		int          status_seen[5];

		function new();
			enable_r = 0;
			qcount_r = 1;
			foreach (prev_cnt[i]) begin
				prev_cnt[i] = '0;
				table_q[i] = '0;
				delta[i] = '0;
			end
		endfunction

		function int eff_queues();
			if (qcount_r == 0)
				return 1;
			if (qcount_r > 16)
				return 16;
			return qcount_r;
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [4:0] data);
			if (idx == CFG_ENABLE)
				enable_r = data[0];
			else
				qcount_r = data;
		endfunction

		function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
			bit [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? '1 : s[63:0];
		endfunction

		function rstat_t decide(int q);
			int        n;
			int        act;
			int        max_q;
			int        min_q;
			bit [63:0] loads[16];
			bit [63:0] total;
			bit [63:0] thr;
			bit [63:0] need;
			bit [63:0] moved_sum;
			bit [63:0] can;
			n = 4 * q;
			act = 0;
			max_q = 0;
			min_q = 0;
			total = '0;
			if (!enable_r || q <= 1)
				return RS_OFF;
			for (int i = 0; i < n; i++)
				if (delta[i] != 0)
					act++;
			if (act <= q)
				return RS_FEW;
			foreach (loads[i])
				loads[i] = '0;
			for (int i = 0; i < n; i++)
				if (table_q[i] < q) begin
					loads[table_q[i]] = sat_add(loads[table_q[i]], delta[i]);
					total = sat_add(total, delta[i]);
				end
			for (int i = 0; i < n; i++)
				if (delta[i] >= total / 2)
					return RS_DOM;
			thr = (total / 64'(q)) / 10;
			for (int i = 1; i < q; i++) begin
				if (loads[i] > loads[max_q])
					max_q = i;
				if (loads[i] < loads[min_q])
					min_q = i;
			end
			if (loads[max_q] - loads[min_q] <= thr || min_q == max_q)
				return RS_BAL;
			need = (loads[max_q] - loads[min_q]) / 2;
			if (need == 0)
				need = 1;
			moved_sum = '0;
			for (int i = 0; i < n && moved_sum < need; i++)
				if (table_q[i] == max_q && delta[i] > 0) begin
					can = delta[i];
					if (can > need - moved_sum)
						can = need - moved_sum;
					table_q[i] = 8'(min_q);
					moved[i] = 1;
					moved_sum += can;
				end
			return RS_REBAL;
		endfunction

		function void note_item(opcode_t op, bit [5:0] idx, bit [63:0] cnt, bit [7:0] qv,
				bit lst);
			int      q;
			rstat_t  st;
			report_t r;
			q = eff_queues();
			case (op)
				OPC_BASE: prev_cnt[idx] = cnt;
				OPC_FILL: for (int i = 0; i < 4 * q; i++)
					table_q[i] = 8'(i % q);
				OPC_WRITE: table_q[idx] = qv;
				default: begin
					if (enable_r && q > 1) begin
						delta[idx] = cnt - prev_cnt[idx];
						prev_cnt[idx] = cnt;
					end
					if (lst) begin
						foreach (moved[i])
							moved[i] = 0;
						st = decide(q);
						foreach (delta[i])
							delta[i] = '0;
						rounds++;
						status_seen[st]++;
						for (int i = 0; i < 4 * q; i++) begin
							r.idx = 6'(i);
							r.queue = table_q[i];
							r.moved = moved[i];
							r.status = st;
							r.lastf = (i == 4 * q - 1);
							pending.push_back(r);
						end
					end
				end
			endcase
		endfunction

		function void check_result(report_t got);
			report_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected report: idx=%0d queue=%0d moved=%0b st=%0d last=%0b",
					$time, got.idx, got.queue, got.moved, got.status, got.lastf);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got !== want) begin
				$display("%0t mismatch exp idx=%0d queue=%0d moved=%0b st=%0d last=%0b",
					$time, want.idx, want.queue, want.moved, want.status, want.lastf);
				$display("%0t          got idx=%0d queue=%0d moved=%0b st=%0d last=%0b",
					$time, got.idx, got.queue, got.moved, got.status, got.lastf);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  start;
	logic                  busy;
	logic [1:0]            opcode;
	logic [IDX_W-1:0]      entry_index;
	logic [63:0]           packet_count;
	logic [QV_W-1:0]       queue_value;
	logic                  last;
	logic                  result_valid;
	logic [IDX_W-1:0]      entry_index_out;
	logic [QV_W-1:0]       queue_out;
	logic                  reassigned;
	logic [2:0]            round_status;
	logic                  last_out;

	rebalance_scoreboard sb;
	int                  items_sent;

	rss_indirection_rebalancer u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .opcode(opcode),
		.entry_index(entry_index), .packet_count(packet_count),
		.queue_value(queue_value), .last(last), .result_valid(result_valid),
		.entry_index_out(entry_index_out), .queue_out(queue_out),
		.reassigned(reassigned), .round_status(round_status), .last_out(last_out)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 3_000_000);
		$display("[rss_indirection_rebalancer] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result({entry_index_out, queue_out, reassigned,
				rstat_t'(round_status), last_out});
	end

	function bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// short gaps or none as a rule, a few long ones
	task automatic gap_after_item();
		int n;
		n = ($urandom_range(0, 9) < 4) ? 0 :
			($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(opcode_t op, bit [5:0] idx, bit [63:0] cnt, bit [7:0] qv,
			bit lst);
		opcode <= op;
		entry_index <= idx;
		packet_count <= cnt;
		queue_value <= qv;
		last <= lst;
		start <= 1;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(op, idx, cnt, qv, lst);
		items_sent++;
		gap_after_item();
	endtask

	task automatic drain();
		start <= 0;
		do
			@(posedge clk);
		while (busy || sb.pending.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [4:0] data);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.note_config(idx, data);
		cfg_we <= 0;
	endtask

	// one count round: table setup, baselines, periodic counts with shaped deltas
	task automatic count_round(int style);
		int        q;
		int        n;
		int        heavy;
		int        hot;
		int        live;
		bit [63:0] d;
		q = sb.eff_queues();
		n = 4 * q;
		heavy = $urandom_range(0, q - 1);
		hot = $urandom_range(0, n - 1);
		live = $urandom_range(1, q);
		if ($urandom_range(0, 3) != 0)
			send_item(OPC_FILL, 6'($urandom), rand64(), 8'($urandom), 1'($urandom));
		repeat ($urandom_range(0, 2))
			send_item(OPC_WRITE, 6'($urandom_range(0, n - 1)), rand64(),
				($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, q - 1)),
				1'($urandom));
		for (int i = 0; i < n; i++)
			if ($urandom_range(0, 5) != 0)
				send_item(OPC_BASE, 6'(i), rand64(), 8'($urandom), 1'($urandom));
		for (int i = 0; i < n; i++) begin
			case (style)
				0: d = 64'(1000 + $urandom_range(0, 20));
				1: d = (sb.table_q[i] == heavy) ? 64'(500 + $urandom_range(0, 500)) :
					64'(50 + $urandom_range(0, 100));
				2: d = (i < live) ? 64'($urandom_range(1, 5000)) : 64'(0);
				3: d = (i == hot) ? 64'(1_000_000) : 64'($urandom_range(1, 100));
				default: d = rand64() >> $urandom_range(0, 63);
			endcase
			if (i == n - 1 || $urandom_range(0, 15) != 0)
				send_item(OPC_COUNT, 6'(i), sb.prev_cnt[i] + d, 8'($urandom), i == n - 1);
		end
	endtask

	initial begin
		logic [4:0] qsel;
		sb = new();
		items_sent = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_ENABLE;
		cfg_data = '0;
		start = 0;
		opcode = OPC_BASE;
		entry_index = '0;
		packet_count = '0;
		queue_value = '0;
		last = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset state: disabled with one queue, every opcode and both last marks
		send_item(OPC_COUNT, 6'd63, '1, 8'hff, 1);
		send_item(OPC_BASE, 6'd63, '1, 8'hff, 1);
		send_item(OPC_WRITE, 6'd63, '1, 8'hff, 1);
		send_item(OPC_WRITE, 6'd2, '0, 8'd200, 0);
		send_item(OPC_FILL, 6'd0, '0, 8'd0, 1);
		send_item(OPC_COUNT, 6'd0, '0, 8'd0, 0);
		send_item(OPC_COUNT, 6'd1, 64'd5, 8'd0, 1);
		// queue count zero and above the maximum
		write_config(CFG_QCOUNT, 5'd0);
		send_item(OPC_COUNT, 6'd3, 64'd7, 8'd0, 1);
		write_config(CFG_QCOUNT, 5'd31);
		send_item(OPC_FILL, 6'd0, '0, 8'd0, 0);
		send_item(OPC_COUNT, 6'd9, '1, 8'd0, 1);
		// enabled: wrapping delta, an out-of-range queue entry, a saturating load total
		write_config(CFG_ENABLE, 5'd1);
		send_item(OPC_WRITE, 6'd5, '0, 8'd255, 0);
		send_item(OPC_BASE, 6'd0, '1, 8'd0, 0);
		send_item(OPC_COUNT, 6'd0, 64'd9, 8'd0, 0);
		for (int i = 1; i < 20; i++)
			send_item(OPC_COUNT, 6'(i), sb.prev_cnt[i] + 64'h7fff_ffff_ffff_0000, 8'd0, 0);
		send_item(OPC_COUNT, 6'd20, sb.prev_cnt[20] + 64'd3, 8'd0, 1);
		write_config(CFG_QCOUNT, 5'd16);
		count_round(1);
		write_config(CFG_QCOUNT, 5'd2);
		count_round(1);
		count_round(0);

		while (items_sent < 380) begin
			if ($urandom_range(0, 7) == 0)
				write_config(CFG_ENABLE, 5'($urandom_range(0, 1)));
			else if (!sb.enable_r)
				write_config(CFG_ENABLE, 5'd1);
			qsel = ($urandom_range(0, 11) == 0) ? 5'($urandom) : 5'($urandom_range(2, 6));
			write_config(CFG_QCOUNT, qsel);
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 4))
					send_item(opcode_t'(2'($urandom)), 6'($urandom), rand64(),
						8'($urandom), 1'($urandom));
			count_round($urandom_range(0, 9) < 4 ? 1 : $urandom_range(0, 4));
		end

		drain();
		repeat (100) @(posedge clk);
		$display("items %0d, rounds %0d, reports checked %0d", items_sent, sb.rounds,
			sb.checked);
		$display("round outcomes rebal/off/few/dom/bal: %0d %0d %0d %0d %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.status_seen[4]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[rss_indirection_rebalancer] OK");
		else
			$display("[rss_indirection_rebalancer] ERROR");
		$finish;
	end
endmodule
